FILE: rtl/trr_pkg.sv
// ----------------------------------------------------------------------------
// trr_pkg
// Shared types and constants for the trace record resequencer.
// ----------------------------------------------------------------------------
package trr_pkg;

    localparam int CORE_SLOTS       = 16;
    localparam int MAX_RECORD_BYTES = 2048;

    localparam int OFF_W      = $clog2(MAX_RECORD_BYTES);
    localparam int CORE_IDX_W = (CORE_SLOTS > 1) ? $clog2(CORE_SLOTS) : 1;

    localparam logic [31:0] HEADER_MAGIC = 32'h5053_4600;
    localparam int          HEADER_LEN   = 32;
    localparam int          STAMP_LEN    = 28;
    localparam int          TABHDR_LEN   = 12;

    // record order
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_STAMP,
        PH_TABHDR,
        PH_ENTRY,
        PH_EVENT
    } phase_t;

    // status codes reported on a record's last byte
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_HDR_LEN     = 3'd1;
    localparam logic [2:0] ST_MAGIC       = 3'd2;
    localparam logic [2:0] ST_STAMP_LEN   = 3'd3;
    localparam logic [2:0] ST_TABHDR_LEN  = 3'd4;
    localparam logic [2:0] ST_ENTRY_LEN   = 3'd5;
    localparam logic [2:0] ST_SHORT_EVENT = 3'd6;
    localparam logic [2:0] ST_REJECTED    = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic [2:0]  record_kind;
        logic [2:0]  status;
        logic        gap_found;
        logic [11:0] missing_count;
        logic [3:0]  gap_core;
    } result_t;

endpackage

FILE: rtl/trr_input_reg.sv
// ----------------------------------------------------------------------------
// trr_input_reg
// Input register: holds one accepted item until the engine takes it.
// ----------------------------------------------------------------------------
module trr_input_reg
    import trr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    input  logic       take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;

    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_valid && s_ready) begin
            valid_next          = 1'b1;
            item_next.data_byte = s_data_byte;
            item_next.last_byte = s_last_byte;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/trr_engine.sv
// ----------------------------------------------------------------------------
// trr_engine
// Record walker: length/magic checks, event gap check and count rewrite.
// ----------------------------------------------------------------------------
module trr_engine
    import trr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  item_t   item,
    output result_t result
);

    phase_t            phase_reg, phase_next;
    logic [OFF_W-1:0]  offset_reg, offset_next;
    logic              over_long_reg, over_long_next;
    logic [31:0]       gather_reg, gather_next;
    logic              magic_reg, magic_next;
    logic [15:0]       core_limit_reg, core_limit_next;
    logic [31:0]       slots_reg, slots_next;
    logic [31:0]       sym_len_reg, sym_len_next;
    logic [31:0]       state_cnt_reg, state_cnt_next;
    logic [31:0]       seen_reg, seen_next;
    logic [11:0]       gcount_reg, gcount_next;
    logic [7:0]        cnt_low_reg, cnt_low_next;
    logic              sticky_reg, sticky_next;
    logic [CORE_SLOTS-1:0] cvalid_reg, cvalid_next;

    logic [11:0]       last_cnt_mem [CORE_SLOTS];

    logic [7:0]            b;
    logic                  last;
    logic [OFF_W-1:0]      off;
    logic [31:0]           shifted;
    logic [31:0]           len32;
    logic [31:0]           expect_len;
    logic [3:0]            core;
    logic [CORE_IDX_W-1:0] core_idx;
    logic [11:0]           cnt;
    logic [11:0]           prev;
    logic [11:0]           diff;
    logic                  in_range;
    logic                  mem_we;
    logic                  fault;

    assign b          = item.data_byte;
    assign last       = item.last_byte;
    assign off        = offset_reg;
    assign shifted    = {b, gather_reg[31:8]};
    assign len32      = {{(32 - OFF_W){1'b0}}, off} + 32'd1;
    assign expect_len = ((state_cnt_reg + 32'd2) << 2) + sym_len_reg;
    assign core       = b[7:4];
    assign core_idx   = core[CORE_IDX_W-1:0];
    assign cnt        = {b[3:0], cnt_low_reg};
    assign prev       = last_cnt_mem[core_idx];
    assign diff       = cnt - prev;  // modulo 4096; zero means a full wrap
    assign in_range   = ({12'd0, core} < core_limit_reg) &&
                        ({1'b0, core} < 5'(CORE_SLOTS));

    always_comb begin
        phase_next     = phase_reg;
        gather_next    = gather_reg;
        magic_next     = magic_reg;
        core_limit_next = core_limit_reg;
        slots_next     = slots_reg;
        sym_len_next   = sym_len_reg;
        state_cnt_next = state_cnt_reg;
        seen_next      = seen_reg;
        gcount_next    = gcount_reg;
        cnt_low_next   = cnt_low_reg;
        cvalid_next    = cvalid_reg;
        sticky_next    = sticky_reg;
        mem_we         = 1'b0;
        fault          = 1'b0;

        result.out_byte      = b;
        result.out_last      = last;
        result.record_kind   = phase_reg;
        result.status        = ST_OK;
        result.gap_found     = 1'b0;
        result.missing_count = 12'd0;
        result.gap_core      = 4'd0;

        if (sticky_reg) begin
            if (last) begin
                result.status = ST_REJECTED;
            end
        end else begin
            case (phase_reg)
                PH_HEADER: begin
                    if (off < OFF_W'(4) || (off >= OFF_W'(12) && off < OFF_W'(16))) begin
                        gather_next = shifted;
                    end
                    if (off == OFF_W'(3)) begin
                        magic_next = (gather_next == HEADER_MAGIC);
                    end
                    if (last) begin
                        if (over_long_reg || off != OFF_W'(HEADER_LEN - 1)) begin
                            result.status = ST_HDR_LEN;
                            fault         = 1'b1;
                        end else if (!magic_reg) begin
                            result.status = ST_MAGIC;
                            fault         = 1'b1;
                        end else if (gather_next != 32'd0) begin
                            core_limit_next = gather_next[15:0];
                            cvalid_next     = '0;
                        end
                        phase_next = PH_STAMP;
                    end
                end
                PH_STAMP: begin
                    if (last) begin
                        if (over_long_reg || off != OFF_W'(STAMP_LEN - 1)) begin
                            result.status = ST_STAMP_LEN;
                            fault         = 1'b1;
                        end
                        phase_next = PH_TABHDR;
                    end
                end
                PH_TABHDR: begin
                    if (off < OFF_W'(12)) begin
                        gather_next = shifted;
                        if (off == OFF_W'(3)) begin
                            slots_next = shifted;
                        end else if (off == OFF_W'(7)) begin
                            sym_len_next = shifted;
                        end else if (off == OFF_W'(11)) begin
                            state_cnt_next = shifted;
                        end
                    end
                    if (last) begin
                        if (over_long_reg || off != OFF_W'(TABHDR_LEN - 1)) begin
                            result.status = ST_TABHDR_LEN;
                            fault         = 1'b1;
                        end
                        phase_next = PH_ENTRY;
                    end
                end
                PH_ENTRY: begin
                    if (last) begin
                        seen_next = seen_reg + 32'd1;
                        if (over_long_reg || len32 != expect_len) begin
                            result.status = ST_ENTRY_LEN;
                            fault         = 1'b1;
                        end
                        if (seen_next >= slots_reg) begin
                            phase_next = PH_EVENT;
                        end
                    end
                end
                default: begin
                    // event records
                    if (off == OFF_W'(2) && !last) begin
                        cnt_low_next    = b;
                        result.out_byte = gcount_reg[7:0];
                    end else if (off == OFF_W'(3)) begin
                        if (in_range) begin
                            if (cvalid_reg[core_idx] && diff != 12'd1) begin
                                result.gap_found     = 1'b1;
                                result.missing_count = diff - 12'd1;
                                result.gap_core      = core;
                            end
                            mem_we                = 1'b1;
                            cvalid_next[core_idx] = 1'b1;
                        end
                        result.out_byte = {b[7:4], gcount_reg[11:8]};
                        gcount_next     = gcount_reg + 12'd1;
                    end
                    if (last && !over_long_reg && off < OFF_W'(3)) begin
                        result.status = ST_SHORT_EVENT;
                    end
                end
            endcase
            if (fault) begin
                sticky_next = 1'b1;
            end
        end

        offset_next    = offset_reg;
        over_long_next = over_long_reg;
        if (last) begin
            offset_next    = '0;
            over_long_next = 1'b0;
        end else if (off < OFF_W'(MAX_RECORD_BYTES - 1)) begin
            offset_next = off + OFF_W'(1);
        end else begin
            over_long_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            offset_reg     <= '0;
            over_long_reg  <= 1'b0;
            gather_reg     <= '0;
            magic_reg      <= 1'b0;
            core_limit_reg <= '0;
            slots_reg      <= '0;
            sym_len_reg    <= '0;
            state_cnt_reg  <= '0;
            seen_reg       <= '0;
            gcount_reg     <= '0;
            cnt_low_reg    <= '0;
            sticky_reg     <= 1'b0;
            cvalid_reg     <= '0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            offset_reg     <= offset_next;
            over_long_reg  <= over_long_next;
            gather_reg     <= gather_next;
            magic_reg      <= magic_next;
            core_limit_reg <= core_limit_next;
            slots_reg      <= slots_next;
            sym_len_reg    <= sym_len_next;
            state_cnt_reg  <= state_cnt_next;
            seen_reg       <= seen_next;
            gcount_reg     <= gcount_next;
            cnt_low_reg    <= cnt_low_next;
            sticky_reg     <= sticky_next;
            cvalid_reg     <= cvalid_next;
        end
    end

    // per-core last counts, only read where the valid bit is set
    always_ff @(posedge aclk) begin
        if (fire && mem_we) begin
            last_cnt_mem[core_idx] <= cnt;
        end
    end

endmodule

FILE: rtl/trr_output_reg.sv
// ----------------------------------------------------------------------------
// trr_output_reg
// Result register on the m_ side.
// ----------------------------------------------------------------------------
module trr_output_reg
    import trr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result,
    output logic    free,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg, valid_next;
    result_t result_reg, result_next;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next  = valid_reg;
        result_next = result_reg;
        if (load) begin
            valid_next  = 1'b1;
            result_next = result;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        result_reg <= result_next;
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

FILE: rtl/trace_record_resequencer.sv
// ----------------------------------------------------------------------------
// Path: input accept to result valid runs through the input register,
//   then the result register; one result per input byte.
// Throughput: one byte per cycle while m_ready keeps the result register
//   draining, set by the combinational record walker between the two registers.
// Reset: synchronous active-low aresetn clears all control state; the
//   per-core count store is not cleared, its valid bits are.
// ----------------------------------------------------------------------------
// trace_record_resequencer
// Walks header, timestamp, table header, table entries and events; checks
// lengths and magic, reports per-core event gaps and rewrites event counts.
// ----------------------------------------------------------------------------
module trace_record_resequencer
    import trr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input item channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    // result item channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_out_last,
    output logic [2:0]  m_record_kind,
    output logic [2:0]  m_status,
    output logic        m_gap_found,
    output logic [11:0] m_missing_count,
    output logic [3:0]  m_gap_core
);

    logic    item_valid;
    item_t   item;
    logic    out_free;
    logic    fire;
    result_t result;
    result_t m_result;

    // an item moves on when the result register is empty or being drained;
    // while a result waits the input register still holds one item
    assign fire = item_valid && out_free;

    trr_input_reg u_input_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .take        (fire),
        .item_valid  (item_valid),
        .item        (item)
    );

    // record state lives here and only moves when an item is processed
    trr_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .result  (result)
    );

    trr_output_reg u_output_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .free     (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_out_byte      = m_result.out_byte;
    assign m_out_last      = m_result.out_last;
    assign m_record_kind   = m_result.record_kind;
    assign m_status        = m_result.status;
    assign m_gap_found     = m_result.gap_found;
    assign m_missing_count = m_result.missing_count;
    assign m_gap_core      = m_result.gap_core;

endmodule

FILE: tb/tb_trace_record_resequencer.sv
// ----------------------------------------------------------------------------
// tb_trace_record_resequencer
// Self-checking bench for the trace record resequencer. A reset is followed
// by one preamble (header, timestamp, table header, table entries), then
// directed and random event records. Every accepted byte runs through a
// behavioural predictor; each result item is compared field by field with
// the oldest prediction. Both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module tb_trace_record_resequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import trr_pkg::*;

    localparam int CLK_HIGH_NS    = 6;
    localparam int CLK_LOW_NS     = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int DRAIN_CYCLES   = 8;     // margin after the last expected result
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no item moving
    localparam int MAX_REPORTS    = 40;
    localparam int SEGMENT_BYTES  = 460;   // random bytes per idling profile

    // ------------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------------
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte   = 8'h00;
    logic        s_last_byte   = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_out_last;
    logic [2:0]  m_record_kind;
    logic [2:0]  m_status;
    logic        m_gap_found;
    logic [11:0] m_missing_count;
    logic [3:0]  m_gap_core;

    always begin
        #CLK_HIGH_NS aclk = 1'b1;
        #CLK_LOW_NS  aclk = 1'b0;
    end

    trace_record_resequencer uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_out_last      (m_out_last),
        .m_record_kind   (m_record_kind),
        .m_status        (m_status),
        .m_gap_found     (m_gap_found),
        .m_missing_count (m_missing_count),
        .m_gap_core      (m_gap_core)
    );

    // ------------------------------------------------------------------------
    // predictor state - a private copy of what the block should hold
    // ------------------------------------------------------------------------
    phase_t      rec_phase     = PH_HEADER;
    int unsigned rec_off       = 0;
    bit          rec_too_long  = 1'b0;
    logic [31:0] gather_word   = '0;
    bit          magic_ok      = 1'b0;
    logic [15:0] core_lim      = '0;
    logic [31:0] table_slots   = '0;
    logic [31:0] sym_len       = '0;
    logic [31:0] state_cnt     = '0;
    logic [31:0] entries_seen  = '0;
    logic [11:0] global_count  = '0;
    logic [11:0] core_prev [CORE_SLOTS] = '{default: 12'h000};
    bit          core_seen [CORE_SLOTS] = '{default: 1'b0};
    logic [7:0]  count_lo      = '0;
    bit          faulted       = 1'b0;

    result_t     expected_results [$];

    // ------------------------------------------------------------------------
    // bench bookkeeping
    // ------------------------------------------------------------------------
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned bytes_sent    = 0;
    int unsigned records_sent  = 0;
    int unsigned error_count   = 0;
    int unsigned gaps_seen     = 0;
    int unsigned shorts_seen   = 0;
    int unsigned rejects_seen  = 0;
    int unsigned stall_cycles  = 0;
    logic [2:0]  fault_code    = ST_OK;   // preamble fault chosen for this seed
    logic [7:0]  record_bytes [$];        // record under construction
    logic [11:0] next_count [CORE_SLOTS] = '{default: 12'h000};
    result_t     got_result;
    result_t     want_result;

    // ------------------------------------------------------------------------
    // predictor: one byte in, one expected result out
    // ------------------------------------------------------------------------
    function automatic result_t resequence_byte(input logic [7:0] b, input logic fin);
        result_t     r;
        int unsigned len;
        int unsigned core;
        int unsigned cnt;
        int unsigned prev;
        int unsigned delta;
        logic [31:0] need;
        r             = '0;
        r.out_byte    = b;
        r.out_last    = fin;
        r.record_kind = rec_phase;
        r.status      = ST_OK;
        len           = rec_too_long ? 0 : rec_off + 1;   // 0 marks over-long

        if (faulted) begin
            // after a fault everything passes untouched, last byte flagged
            if (fin) r.status = ST_REJECTED;
        end else begin
            case (rec_phase)
                PH_HEADER: begin
                    // magic in bytes 0..3, core count in 12..15, little-endian
                    if (rec_off < 4 || (rec_off >= 12 && rec_off < 16))
                        gather_word = {b, gather_word[31:8]};
                    if (rec_off == 3) magic_ok = (gather_word == HEADER_MAGIC);
                    if (fin) begin
                        if (len != HEADER_LEN) r.status = ST_HDR_LEN;
                        else if (!magic_ok) r.status = ST_MAGIC;
                        else if (gather_word != 0) begin
                            core_lim  = gather_word[15:0];
                            core_seen = '{default: 1'b0};
                        end
                        rec_phase = PH_STAMP;
                    end
                end
                PH_STAMP: begin
                    if (fin) begin
                        if (len != STAMP_LEN) r.status = ST_STAMP_LEN;
                        rec_phase = PH_TABHDR;
                    end
                end
                PH_TABHDR: begin
                    if (rec_off < 12) begin
                        gather_word = {b, gather_word[31:8]};
                        if (rec_off == 3) table_slots = gather_word;
                        else if (rec_off == 7) sym_len = gather_word;
                        else if (rec_off == 11) state_cnt = gather_word;
                    end
                    if (fin) begin
                        if (len != TABHDR_LEN) r.status = ST_TABHDR_LEN;
                        rec_phase = PH_ENTRY;
                    end
                end
                PH_ENTRY: begin
                    if (fin) begin
                        need         = (state_cnt + 32'd2) * 32'd4 + sym_len;  // mod 2^32
                        entries_seen = entries_seen + 32'd1;
                        if (len == 0 || len != need) r.status = ST_ENTRY_LEN;
                        if (entries_seen >= table_slots) rec_phase = PH_EVENT;
                    end
                end
                default: begin
                    if (rec_off == 2 && !fin) begin
                        count_lo   = b;
                        r.out_byte = global_count[7:0];
                    end else if (rec_off == 3) begin
                        core = b[7:4];
                        cnt  = {b[3:0], count_lo};
                        if (core < core_lim && core < CORE_SLOTS) begin
                            if (core_seen[core]) begin
                                prev  = core_prev[core];
                                delta = (cnt > prev) ? cnt - prev : 4096 - prev + cnt;
                                if (delta > 1) begin
                                    r.gap_found     = 1'b1;
                                    r.missing_count = 12'(delta - 1);
                                    r.gap_core      = 4'(core);
                                end
                            end
                            core_prev[core] = 12'(cnt);
                            core_seen[core] = 1'b1;
                        end
                        // keep the core nibble, substitute the global count
                        r.out_byte   = {b[7:4], global_count[11:8]};
                        global_count = global_count + 12'd1;
                    end
                    if (fin && len != 0 && len < 4) r.status = ST_SHORT_EVENT;
                end
            endcase
            if (r.status >= ST_HDR_LEN && r.status <= ST_ENTRY_LEN) faulted = 1'b1;
        end

        if (fin) begin
            rec_off      = 0;
            rec_too_long = 1'b0;
        end else if (rec_off < MAX_RECORD_BYTES - 1) begin
            rec_off = rec_off + 1;
        end else begin
            rec_too_long = 1'b1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // record building
    // ------------------------------------------------------------------------
    function automatic void push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) record_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void push_random(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) record_bytes.push_back(8'($urandom));
    endfunction

    // trim or pad the record under construction to n bytes
    function automatic void fit_length(input int unsigned n);
        while (record_bytes.size() > n) void'(record_bytes.pop_back());
        while (record_bytes.size() < n) record_bytes.push_back(8'($urandom));
    endfunction

    function automatic int unsigned bad_length(input int unsigned good);
        case ($urandom_range(0, 2))
            0:       return good - 1;
            1:       return good + 1;
            default: return MAX_RECORD_BYTES + 2;   // over-long
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // sender: one item per call, prediction taken at acceptance
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] d, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= d;
        s_last_byte <= fin;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(resequence_byte(d, fin));
        bytes_sent++;
    endtask

    task automatic send_record();
        int unsigned n;
        n = record_bytes.size();
        for (int unsigned i = 0; i < n; i++) send_byte(record_bytes[i], i == n - 1);
        record_bytes.delete();
        records_sent++;
    endtask

    // event record: two free bytes, then count low, then core nibble and count high
    task automatic send_event(input logic [3:0] core, input logic [11:0] cnt,
                              input int unsigned len);
        push_random(2);
        record_bytes.push_back(cnt[7:0]);
        record_bytes.push_back({core, cnt[11:8]});
        push_random(len - 4);
        send_record();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // Header, timestamp, table header and entries. The seed picks the core
    // count, the table layout and, now and then, one preamble fault; a fault
    // is sticky, so for that seed every later record must be rejected.
    task automatic test_preamble();
        logic [31:0] core_word;
        logic [31:0] slot_word;
        logic [31:0] sym_word;
        logic [31:0] state_word;
        logic [31:0] entry_len;
        int unsigned n_entries;
        int unsigned k;
        if ($urandom_range(0, 4) == 0)
            fault_code = 3'($urandom_range(ST_HDR_LEN, ST_ENTRY_LEN));

        case ($urandom_range(0, 9))
            0:       core_word = 32'h0000_0000;               // gap detection off
            1:       core_word = 32'h0000_FFFF;               // limit above the slots
            2:       core_word = {16'($urandom_range(1, 16'hFFFF)), 16'd16};  // high half ignored
            3, 4:    core_word = 32'($urandom_range(1, 15));  // some cores out of range
            default: core_word = 32'd16;
        endcase
        push_word(HEADER_MAGIC);
        push_random(8);
        push_word(core_word);
        push_random(16);
        if (fault_code == ST_HDR_LEN) fit_length(bad_length(HEADER_LEN));
        if (fault_code == ST_MAGIC)
            record_bytes[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        send_record();

        push_random(STAMP_LEN);
        if (fault_code == ST_STAMP_LEN) fit_length(bad_length(STAMP_LEN));
        send_record();

        // entry length is (states + 2) * 4 + symbol length, wrapping at 2^32
        slot_word = 32'($urandom_range(0, 3));     // zero still takes one entry
        case ($urandom_range(0, 3))
            0: begin
                state_word = 32'hFFFF_FFFF;
                sym_word   = 32'($urandom_range(0, 20));
            end
            1: begin
                state_word = 32'($urandom_range(0, 5));
                k          = $urandom_range(1, 7);
                sym_word   = 32'(k) - (state_word + 32'd2) * 32'd4;
            end
            default: begin
                state_word = 32'($urandom_range(0, 6));
                sym_word   = 32'($urandom_range(0, 30));
            end
        endcase
        push_word(slot_word);
        push_word(sym_word);
        push_word(state_word);
        if (fault_code == ST_TABHDR_LEN) fit_length(bad_length(TABHDR_LEN));
        send_record();

        entry_len = (state_word + 32'd2) * 32'd4 + sym_word;
        n_entries = (slot_word == 0) ? 1 : slot_word;
        for (int unsigned i = 0; i < n_entries; i++) begin
            push_random(entry_len);
            if (i == 0 && fault_code == ST_ENTRY_LEN) fit_length(entry_len + 1);
            send_record();
        end
    endtask

    // Directed event records: first count of a core, plain increment, gap,
    // wrap through zero, repeated count, backwards step, top core, and the
    // three lengths too short to carry a count.
    task automatic test_event_cases();
        send_event(4'd0,  12'h000, 4);
        send_event(4'd0,  12'h001, 4);
        send_event(4'd0,  12'h005, 5);
        send_event(4'd0,  12'hFFF, 4);
        send_event(4'd0,  12'h000, 4);
        send_event(4'd0,  12'h000, 6);
        send_event(4'd0,  12'h800, 4);
        send_event(4'd0,  12'h7FF, 4);
        send_event(4'd15, 12'hABC, 4);
        send_event(4'd15, 12'hFFF, 9);
        record_bytes = '{8'hFF};
        send_record();
        record_bytes = '{8'h00, 8'hFF};
        send_record();
        record_bytes = '{8'hFF, 8'h00, 8'h80};
        send_record();
        next_count[0]  = 12'h7FF;
        next_count[15] = 12'hFFF;
    endtask

    // Mostly well-formed events with per-core counts that advance by one,
    // with skips, repeats and back-steps mixed in; the rest short or junk.
    task automatic test_random_traffic(input int unsigned n_bytes);
        int unsigned first_byte;
        int unsigned pick;
        int unsigned len;
        logic [3:0]  core;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                push_random($urandom_range(1, 3));
                send_record();
            end else if (pick < 13) begin
                push_random($urandom_range(4, 10));
                send_record();
            end else begin
                core = 4'($urandom_range(0, 15));
                pick = $urandom_range(0, 99);
                if (pick < 80)      next_count[core] = next_count[core] + 12'd1;
                else if (pick < 88) next_count[core] = next_count[core]
                                                       + 12'($urandom_range(2, 60));
                else if (pick < 92) next_count[core] = next_count[core];
                else if (pick < 96) next_count[core] = 12'($urandom);
                else                next_count[core] = next_count[core]
                                                       - 12'($urandom_range(1, 40));
                len = ($urandom_range(0, 99) < 85) ? $urandom_range(4, 12)
                                                   : $urandom_range(13, 40);
                send_event(core, next_count[core], len);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver throttle
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_result = {m_out_byte, m_out_last, m_record_kind, m_status,
                          m_gap_found, m_missing_count, m_gap_core};
            if (got_result.gap_found === 1'b1) gaps_seen++;
            if (got_result.status === ST_SHORT_EVENT) shorts_seen++;
            if (got_result.status === ST_REJECTED) rejects_seen++;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t ns: unexpected result, expected none, actual byte %0h",
                             $time, m_out_byte);
            end else begin
                want_result = expected_results.pop_front();
                check_field("out_byte",      want_result.out_byte,      got_result.out_byte);
                check_field("out_last",      want_result.out_last,      got_result.out_last);
                check_field("record_kind",   want_result.record_kind,
                            got_result.record_kind);
                check_field("status",        want_result.status,        got_result.status);
                check_field("gap_found",     want_result.gap_found,     got_result.gap_found);
                check_field("missing_count", want_result.missing_count,
                            got_result.missing_count);
                check_field("gap_core",      want_result.gap_core,      got_result.gap_core);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: a hung handshake ends the run
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_trace_record_resequencer: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        send_idle_pct = 7;
        recv_idle_pct = 78;
        test_preamble();
        test_event_cases();
        test_random_traffic(SEGMENT_BYTES);

        // and the other way round
        send_idle_pct = 78;
        recv_idle_pct = 7;
        test_random_traffic(SEGMENT_BYTES);

        // flat out
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(SEGMENT_BYTES);
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d bytes in %0d records: %0d gaps, %0d short events, %0d rejected",
                 bytes_sent, records_sent, gaps_seen, shorts_seen, rejects_seen);
        $display("core limit %0h, table slots %0d, preamble fault code %0d",
                 core_lim, table_slots, fault_code);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb_trace_record_resequencer: done, clean");
        end else begin
            $display("tb_trace_record_resequencer: done, errors");
        end
        $finish;
    end

endmodule
